// ===== hw/rtl/udbar_pkg.sv =====
// Shared types and constants for the up/down button auto-repeat block.
package udbar_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned ValueWidth = 8;
  localparam int unsigned ModeWidth = 3;

  localparam logic [CfgIdxWidth-1:0] CFG_SHORT_HOLD = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_LONG_HOLD = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_SLOW_PERIOD = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_FAST_PERIOD = 3'd3;

  localparam logic [CfgWidth-1:0] SHORT_HOLD_RST = 16'd100;
  localparam logic [CfgWidth-1:0] LONG_HOLD_RST = 16'd300;
  localparam logic [CfgWidth-1:0] SLOW_PERIOD_RST = 16'd20;
  localparam logic [CfgWidth-1:0] FAST_PERIOD_RST = 16'd5;

  typedef enum logic [ModeWidth-1:0] {
    MODE_IDLE      = 3'd0,
    MODE_STEP_UP   = 3'd1,
    MODE_SLOW_UP   = 3'd2,
    MODE_FAST_UP   = 3'd3,
    MODE_STEP_DOWN = 3'd4,
    MODE_SLOW_DOWN = 3'd5,
    MODE_FAST_DOWN = 3'd6
  } mode_e;

  typedef struct packed {
    logic raw_increase;
    logic raw_decrease;
  } in_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [ModeWidth-1:0]  mode;
  } out_t;

  typedef struct packed {
    logic [CfgWidth-1:0] short_hold;
    logic [CfgWidth-1:0] long_hold;
    logic [CfgWidth-1:0] slow_period;
    logic [CfgWidth-1:0] fast_period;
  } cfg_t;

endpackage

// ===== hw/rtl/udbar_step.sv =====
// Per-tick button sampling, hold counters and mode handler.
module udbar_step import udbar_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  cfg_t                   cfg_i,
  input  in_t                    in_i,
  input  logic                   last_inc_i,
  input  logic                   last_dec_i,
  input  logic [COUNT_WIDTH-1:0] inc_hold_i,
  input  logic [COUNT_WIDTH-1:0] dec_hold_i,
  input  logic [COUNT_WIDTH-1:0] slow_ticks_i,
  input  logic [COUNT_WIDTH-1:0] fast_ticks_i,
  input  mode_e                  mode_i,
  input  logic [ValueWidth-1:0]  value_i,
  output logic [COUNT_WIDTH-1:0] inc_hold_o,
  output logic [COUNT_WIDTH-1:0] dec_hold_o,
  output logic [COUNT_WIDTH-1:0] slow_ticks_o,
  output logic [COUNT_WIDTH-1:0] fast_ticks_o,
  output mode_e                  mode_o,
  output logic [ValueWidth-1:0]  value_o
);

  localparam int unsigned CmpWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;

  logic inc_press, dec_press, any_release;
  logic [COUNT_WIDTH-1:0] hold_sel, hold_adv;
  logic [COUNT_WIDTH-1:0] ih, dh, st, ft;
  logic ih_gt_short, ih_gt_long, dh_gt_short, dh_gt_long;
  logic slow_due, fast_due;

  assign inc_press   = (in_i.raw_increase == last_inc_i) && !in_i.raw_increase;
  assign dec_press   = (in_i.raw_decrease == last_dec_i) && !in_i.raw_decrease;
  assign any_release = ((in_i.raw_increase == last_inc_i) && in_i.raw_increase) ||
                       ((in_i.raw_decrease == last_dec_i) && in_i.raw_decrease);

  assign hold_sel = inc_press ? inc_hold_i : dec_hold_i;
  assign hold_adv = (hold_sel == '1) ? hold_sel : hold_sel + 1'b1;

  // button update
  always_comb begin
    ih = inc_hold_i;
    dh = dec_hold_i;
    st = slow_ticks_i;
    ft = fast_ticks_i;
    if (inc_press || dec_press) begin
      if (inc_press) begin
        ih = hold_adv;
      end else begin
        dh = hold_adv;
      end
      if (CmpWidth'(hold_adv) > CmpWidth'(cfg_i.short_hold)) begin
        st = (slow_ticks_i == '1) ? slow_ticks_i : slow_ticks_i + 1'b1;
      end
      if (CmpWidth'(hold_adv) > CmpWidth'(cfg_i.long_hold)) begin
        ft = (fast_ticks_i == '1) ? fast_ticks_i : fast_ticks_i + 1'b1;
      end
    end else if (any_release) begin
      ih = '0;
      dh = '0;
    end
  end

  assign ih_gt_short = CmpWidth'(ih) > CmpWidth'(cfg_i.short_hold);
  assign ih_gt_long  = CmpWidth'(ih) > CmpWidth'(cfg_i.long_hold);
  assign dh_gt_short = CmpWidth'(dh) > CmpWidth'(cfg_i.short_hold);
  assign dh_gt_long  = CmpWidth'(dh) > CmpWidth'(cfg_i.long_hold);
  assign slow_due    = CmpWidth'(st) > CmpWidth'(cfg_i.slow_period);
  assign fast_due    = CmpWidth'(ft) > CmpWidth'(cfg_i.fast_period);

  // mode handler
  always_comb begin
    inc_hold_o   = ih;
    dec_hold_o   = dh;
    slow_ticks_o = st;
    fast_ticks_o = ft;
    mode_o       = mode_i;
    value_o      = value_i;
    unique case (mode_i)
      MODE_STEP_UP: begin
        if (ih == '0) mode_o = MODE_IDLE;
        if (ih_gt_short) mode_o = MODE_SLOW_UP;
      end
      MODE_SLOW_UP: begin
        if (ih == '0) mode_o = MODE_IDLE;
        if (ih_gt_long) mode_o = MODE_FAST_UP;
        if (slow_due) begin
          value_o      = value_i + 1'b1;
          slow_ticks_o = '0;
        end
      end
      MODE_FAST_UP: begin
        if (ih == '0) mode_o = MODE_IDLE;
        if (fast_due) begin
          value_o      = value_i + 1'b1;
          fast_ticks_o = '0;
        end
      end
      MODE_STEP_DOWN: begin
        if ((dh == '0) || (ih != '0)) mode_o = MODE_IDLE;
        if (dh_gt_short) mode_o = MODE_SLOW_DOWN;
      end
      MODE_SLOW_DOWN: begin
        if ((dh == '0) || (ih != '0)) mode_o = MODE_IDLE;
        if (dh_gt_long) mode_o = MODE_FAST_DOWN;
        if (slow_due) begin
          value_o      = value_i - 1'b1;
          slow_ticks_o = '0;
        end
      end
      MODE_FAST_DOWN: begin
        if ((dh == '0) || (ih != '0)) mode_o = MODE_IDLE;
        if (fast_due) begin
          value_o      = value_i - 1'b1;
          fast_ticks_o = '0;
        end
      end
      default: begin
        slow_ticks_o = '0;
        fast_ticks_o = '0;
        if (ih != '0) begin
          value_o = value_i + 1'b1;
          mode_o  = MODE_STEP_UP;
        end else if (dh != '0) begin
          value_o = value_i - 1'b1;
          mode_o  = MODE_STEP_DOWN;
        end else begin
          mode_o = MODE_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/up_down_button_auto_repeat_top.sv =====
// Up/down button auto-repeat counter: top level with channel registers and state.
//
// Each input beat is one tick carrying the two active-low button levels; each
// tick yields one result beat with the 8-bit value and the mode after it. The
// block sustains one beat per cycle while out_stall_i stays low. A beat
// lands in an input register, and the step logic moves it into the state
// registers, which also form the result register.
// While a result waits on out_stall_i, one more beat is taken and held in the
// input register. Configuration writes take effect on the next tick and
// must be made while no tick is in flight; writes to indexes above three
// are ignored.
module up_down_button_auto_repeat_top import udbar_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_t                    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_t                   out_data_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i
);

  cfg_t cfg_q;
  logic in_vld_q, out_vld_q;
  in_t  in_q;
  logic adv;
  logic last_inc_q, last_dec_q;
  logic [COUNT_WIDTH-1:0] inc_hold_q, dec_hold_q, slow_ticks_q, fast_ticks_q;
  logic [COUNT_WIDTH-1:0] inc_hold_d, dec_hold_d, slow_ticks_d, fast_ticks_d;
  mode_e mode_q, mode_d;
  logic [ValueWidth-1:0] value_q, value_d;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_hold  <= SHORT_HOLD_RST;
      cfg_q.long_hold   <= LONG_HOLD_RST;
      cfg_q.slow_period <= SLOW_PERIOD_RST;
      cfg_q.fast_period <= FAST_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT_HOLD:  cfg_q.short_hold  <= cfg_wdata_i;
        CFG_LONG_HOLD:   cfg_q.long_hold   <= cfg_wdata_i;
        CFG_SLOW_PERIOD: cfg_q.slow_period <= cfg_wdata_i;
        CFG_FAST_PERIOD: cfg_q.fast_period <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  udbar_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .cfg_i       (cfg_q),
    .in_i        (in_q),
    .last_inc_i  (last_inc_q),
    .last_dec_i  (last_dec_q),
    .inc_hold_i  (inc_hold_q),
    .dec_hold_i  (dec_hold_q),
    .slow_ticks_i(slow_ticks_q),
    .fast_ticks_i(fast_ticks_q),
    .mode_i      (mode_q),
    .value_i     (value_q),
    .inc_hold_o  (inc_hold_d),
    .dec_hold_o  (dec_hold_d),
    .slow_ticks_o(slow_ticks_d),
    .fast_ticks_o(fast_ticks_d),
    .mode_o      (mode_d),
    .value_o     (value_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q    <= 1'b0;
      last_inc_q   <= 1'b1;
      last_dec_q   <= 1'b1;
      inc_hold_q   <= '0;
      dec_hold_q   <= '0;
      slow_ticks_q <= '0;
      fast_ticks_q <= '0;
      mode_q       <= MODE_IDLE;
      value_q      <= '0;
    end else begin
      if (adv) begin
        out_vld_q    <= 1'b1;
        last_inc_q   <= in_q.raw_increase;
        last_dec_q   <= in_q.raw_decrease;
        inc_hold_q   <= inc_hold_d;
        dec_hold_q   <= dec_hold_d;
        slow_ticks_q <= slow_ticks_d;
        fast_ticks_q <= fast_ticks_d;
        mode_q       <= mode_d;
        value_q      <= value_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_data_o.value = value_q;
  assign out_data_o.mode  = mode_q;

`ifndef ASSERT_OFF
  a_value_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(value_q) && $stable(mode_q))
    else $error("state changed without a tick");

  a_value_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (value_q == $past(value_q)) ||
            (value_q == ValueWidth'($past(value_q) + 1'b1)) ||
            (value_q == ValueWidth'($past(value_q) - 1'b1)))
    else $error("value moved by more than one step");

  a_up_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_STEP_UP || mode_q == MODE_SLOW_UP || mode_q == MODE_FAST_UP)
      |-> (inc_hold_q != '0))
    else $error("up mode without increase hold");

  a_down_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_STEP_DOWN || mode_q == MODE_SLOW_DOWN || mode_q == MODE_FAST_DOWN)
      |-> (dec_hold_q != '0))
    else $error("down mode without decrease hold");
`endif

endmodule
